>>> design/dss_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the disk seek scheduler
package dss_pkg;
    localparam int QUEUE_DEPTH = 32;
    localparam int TRACK_BITS  = 16;
    localparam int ID_BITS     = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = ID_BITS + TRACK_BITS + 1;

    localparam logic [2:0] MODE_FIFO  = 3'd0;
    localparam logic [2:0] MODE_SSTF  = 3'd1;
    localparam logic [2:0] MODE_LOOK  = 3'd2;
    localparam logic [2:0] MODE_CLOOK = 3'd3;
    localparam logic [2:0] MODE_FLOOK = 3'd4;

    localparam logic CMD_ENQ  = 1'b0;
    localparam logic CMD_PICK = 1'b1;

    localparam logic [1:0] STAT_ENQ   = 2'd0;
    localparam logic [1:0] STAT_GRANT = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_SHIFT,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        KEY_ZERO,
        KEY_UP,
        KEY_DOWN,
        KEY_ABS,
        KEY_TRACK
    } key_mode_t;
endpackage

>>> design/dss_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module dss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> design/disk_seek_scheduler.sv
`timescale 1ns / 1ps
// disk seek scheduler top level: request store, scan sequencer and ports
//
// Input transactions carry a command in s_axis_tuser (0 enqueue, 1 pick) and
// request id, request track and head track in s_axis_tdata. Every input
// transaction yields exactly one result transaction: status in m_axis_tuser,
// granted id/track, sweep direction and active set in m_axis_tdata.
// An enqueue goes straight from idle to the result state. A pick scans the
// store through one ram read port and one subtract/compare unit, one entry
// per cycle; fifo and shortest seek use one pass, look and circular look up
// to two, flip-set look up to four. A grant then shifts the younger entries
// down one place.
// The input is taken only while the sequencer is idle; a finished result
// waits in the output register while the sequencer already takes the next
// transaction, and the sequencer holds a new result until the receiver
// takes the old one.
// Reset (aresetn low, synchronous) empties the store, sets the sweep upward,
// selects set zero and policy fifo. The policy register is written over apb.
module disk_seek_scheduler
    import dss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // request_id [15:0], request_track [31:16], head_track [47:32]
    input  logic [47:0] s_axis_tdata,
    // command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // granted_id [15:0], granted_track [31:16], direction_up [32],
    // active_queue_now [33], zero fill [39:34]
    output logic [39:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    seq_state_t              state_reg, state_next;
    logic [2:0]              mode_reg, mode_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    sweep_reg, sweep_next;
    logic                    active_reg, active_next;
    logic [1:0]              pass_reg, pass_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pidx_reg, pidx_next;
    logic                    bvld_reg, bvld_next;
    logic [TRACK_BITS-1:0]   bd_reg, bd_next;
    logic [IDX_W-1:0]        bidx_reg, bidx_next;
    logic [ID_BITS-1:0]      bid_reg, bid_next;
    logic [TRACK_BITS-1:0]   btrk_reg, btrk_next;
    logic [TRACK_BITS-1:0]   head_reg, head_next;
    logic [1:0]              stat_reg, stat_next;
    logic                    mval_reg, mval_next;
    logic [1:0]              mstat_reg, mstat_next;
    logic [ID_BITS-1:0]      mid_reg, mid_next;
    logic [TRACK_BITS-1:0]   mtrk_reg, mtrk_next;
    logic                    mdir_reg, mdir_next;
    logic                    mact_reg, mact_next;

    logic                    ram_we, ram_re;
    logic [IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;

    logic [ID_BITS-1:0]      e_id;
    logic [TRACK_BITS-1:0]   e_trk;
    logic                    e_set;
    logic                    ge, elig;
    logic [TRACK_BITS-1:0]   key;
    key_mode_t               kmode;
    logic                    pass_up, mode_look, mode_clook, mode_flook, mode_sstf;
    logic                    in_acc, cfg_wr, pass_end;

    dss_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == SEQ_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata        = (paddr[2] == 1'b0) ? {29'd0, mode_reg} : 32'd0;

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tuser  = mstat_reg;
    assign m_axis_tdata  = {6'd0, mact_reg, mdir_reg, mtrk_reg, mid_reg};

    assign e_id  = ram_rdata[ID_BITS-1:0];
    assign e_trk = ram_rdata[ID_BITS+TRACK_BITS-1:ID_BITS];
    assign e_set = ram_rdata[ENTRY_W-1];

    assign mode_sstf  = (mode_reg == MODE_SSTF);
    assign mode_look  = (mode_reg == MODE_LOOK);
    assign mode_clook = (mode_reg == MODE_CLOOK);
    assign mode_flook = (mode_reg == MODE_FLOOK);
    assign pass_up    = mode_clook ? 1'b1 : (sweep_reg ^ pass_reg[0]);
    assign pass_end   = (issue_reg >= count_reg) && !pend_reg;

    // key selection for the shared distance unit
    always_comb begin
        if (mode_sstf) begin
            kmode = KEY_ABS;
        end else if (mode_look || mode_flook || (mode_clook && pass_reg == 2'd0)) begin
            kmode = pass_up ? KEY_UP : KEY_DOWN;
        end else if (mode_clook) begin
            kmode = KEY_TRACK;
        end else begin
            kmode = KEY_ZERO;
        end
    end

    // shared subtract and eligibility unit
    always_comb begin
        ge   = (e_trk >= head_reg);
        key  = ge ? (e_trk - head_reg) : (head_reg - e_trk);
        elig = 1'b1;
        case (kmode)
            KEY_ZERO:  key = '0;
            KEY_UP:    elig = ge;
            KEY_DOWN:  elig = (e_trk <= head_reg);
            KEY_ABS:   elig = 1'b1;
            KEY_TRACK: key = e_trk;
            default:   key = '0;
        endcase
        if (mode_flook && (e_set != active_reg)) begin
            elig = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= SEQ_IDLE;
            mode_reg   <= MODE_FIFO;
            count_reg  <= '0;
            sweep_reg  <= 1'b1;
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            sweep_reg  <= sweep_next;
            active_reg <= active_next;
            pend_reg   <= pend_next;
            mval_reg   <= mval_next;
        end
        pass_reg  <= pass_next;
        issue_reg <= issue_next;
        pidx_reg  <= pidx_next;
        bvld_reg  <= bvld_next;
        bd_reg    <= bd_next;
        bidx_reg  <= bidx_next;
        bid_reg   <= bid_next;
        btrk_reg  <= btrk_next;
        head_reg  <= head_next;
        stat_reg  <= stat_next;
        mstat_reg <= mstat_next;
        mid_reg   <= mid_next;
        mtrk_reg  <= mtrk_next;
        mdir_reg  <= mdir_next;
        mact_reg  <= mact_next;
    end

    always_comb begin
        state_next  = state_reg;
        mode_next   = cfg_wr ? pwdata[2:0] : mode_reg;
        count_next  = count_reg;
        sweep_next  = sweep_reg;
        active_next = active_reg;
        pass_next   = pass_reg;
        issue_next  = issue_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        bvld_next   = bvld_reg;
        bd_next     = bd_reg;
        bidx_next   = bidx_reg;
        bid_next    = bid_reg;
        btrk_next   = btrk_reg;
        head_next   = head_reg;
        stat_next   = stat_reg;
        mval_next   = mval_reg && !m_axis_tready;
        mstat_next  = mstat_reg;
        mid_next    = mid_reg;
        mtrk_next   = mtrk_reg;
        mdir_next   = mdir_reg;
        mact_next   = mact_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[IDX_W-1:0];
        ram_wdata   = {~active_reg, s_axis_tdata[16+TRACK_BITS-1:16],
                       s_axis_tdata[ID_BITS-1:0]};
        ram_re      = 1'b0;
        ram_raddr   = issue_reg[IDX_W-1:0];

        case (state_reg)
            SEQ_IDLE: begin
                if (in_acc) begin
                    head_next = s_axis_tdata[32+TRACK_BITS-1:32];
                    bid_next  = '0;
                    btrk_next = '0;
                    pass_next = 2'd0;
                    issue_next = '0;
                    bvld_next = 1'b0;
                    state_next = SEQ_DONE;
                    if (s_axis_tuser == CMD_ENQ) begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                            stat_next = STAT_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            stat_next  = STAT_ENQ;
                        end
                    end else if (!mode_flook && count_reg == '0) begin
                        stat_next = STAT_EMPTY;
                    end else begin
                        state_next = SEQ_SCAN;
                    end
                end
            end
            SEQ_SCAN: begin
                if (issue_reg < count_reg) begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (pend_reg && elig && (!bvld_reg || key < bd_reg)) begin
                    bvld_next = 1'b1;
                    bd_next   = key;
                    bidx_next = pidx_reg;
                    bid_next  = e_id;
                    btrk_next = e_trk;
                end
                if (pass_end) begin
                    issue_next = '0;
                    bvld_next  = 1'b0;
                    if (bvld_reg) begin
                        // a hit on the opposite side turns the sweep around
                        if ((mode_look || mode_flook) && pass_reg[0]) begin
                            sweep_next = ~sweep_reg;
                        end
                        stat_next  = STAT_GRANT;
                        issue_next = CNT_W'(bidx_reg) + CNT_W'(1);
                        state_next = SEQ_SHIFT;
                    end else if ((mode_flook && pass_reg != 2'd3) ||
                                 ((mode_look || mode_clook) && pass_reg == 2'd0)) begin
                        pass_next = pass_reg + 2'd1;
                        // active set found empty on both sides: swap sets
                        if (mode_flook && pass_reg == 2'd1) begin
                            active_next = ~active_reg;
                        end
                    end else begin
                        stat_next  = STAT_EMPTY;
                        bid_next   = '0;
                        btrk_next  = '0;
                        state_next = SEQ_DONE;
                    end
                end
            end
            SEQ_SHIFT: begin
                if (issue_reg < count_reg) begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    pidx_next  = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg - IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (pass_end) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = SEQ_DONE;
                end
            end
            SEQ_DONE: begin
                if (!mval_reg || m_axis_tready) begin
                    mval_next  = 1'b1;
                    mstat_next = stat_reg;
                    mid_next   = bid_reg;
                    mtrk_next  = btrk_reg;
                    mdir_next  = sweep_reg;
                    mact_next  = active_reg;
                    state_next = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond store depth");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_axis_tready)
        else $error("input taken while previous transaction in work");

    a_shift_has_winner: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SEQ_SHIFT) |-> (stat_reg == STAT_GRANT && count_reg != '0))
        else $error("shift without a granted entry");
endmodule
